// ===== hdl/crs_pkg.sv =====
package crs_pkg;

    localparam int COORD_BITS = 24;
    localparam int T_BITS     = 16;

    localparam int AXES     = 3;
    localparam int POINTS   = 4;
    localparam int NUM_PROD = AXES * POINTS;

    // Multiplier operand A holds a coordinate or an unsigned power of t.
    localparam int MA_W  = (COORD_BITS > T_BITS + 1) ? COORD_BITS : T_BITS + 1;
    // Doubled basis weights stay well inside +/- 16 * 2^T_BITS.
    localparam int WGT_W = T_BITS + 5;
    localparam int PW    = MA_W + WGT_W;
    localparam int ACC_W = COORD_BITS + T_BITS + 8;
    localparam int QW    = ACC_W - T_BITS - 1;

    localparam int PC_W = 5;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [T_BITS-1:0]     frac_t;
    typedef logic signed [WGT_W-1:0]      wgt_t;
    typedef logic signed [ACC_W-1:0]      acc_t;
    typedef logic signed [QW-1:0]         quot_t;

    localparam logic       COMMAND_PUSH = 1'b0;
    localparam logic       COMMAND_EVAL = 1'b1;

    localparam wgt_t  TWO_S    = WGT_W'(1) << (T_BITS + 1);
    localparam acc_t  ACC_HALF = ACC_W'(1) << T_BITS;
    localparam quot_t Q_MAX    = QW'((64'(1) << (COORD_BITS - 1)) - 64'(1));
    localparam quot_t Q_MIN    = -Q_MAX - QW'(1);

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_TT,
        MUL_T2T,
        MUL_PH
    } mul_op_t;

    typedef enum logic [2:0] {
        JC_NEXT,
        JC_GOTO,
        JC_WAIT_IN,
        JC_IF_PUSH,
        JC_IF_SHORT,
        JC_WAIT_OUT
    } jc_t;

    // One microcode word.
    typedef struct packed {
        logic            in_take;
        mul_op_t         mul_op;
        logic [1:0]      mul_axis;
        logic [1:0]      mul_pt;
        logic            ld_t2;
        logic            ld_t3;
        logic            ld_h;
        logic            acc_en;
        logic            acc_load;
        logic [1:0]      acc_axis;
        logic            out_wr;
        logic            out_zero;
        logic            push_en;
        jc_t             jc;
        logic [PC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic in_valid;
        logic is_push;
        logic full;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic   ready_res;
        coord_t qx;
        coord_t qy;
        coord_t qz;
        logic   clipped;
    } res_t;

endpackage

// ===== hdl/crs_in_if.sv =====
interface crs_in_if
    import crs_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   command;
    coord_t px;
    coord_t py;
    coord_t pz;
    frac_t  param_t;

    modport source (output valid, command, px, py, pz, param_t, input ready);
    modport sink   (input valid, command, px, py, pz, param_t, output ready);
endinterface

// ===== hdl/crs_out_if.sv =====
interface crs_out_if
    import crs_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   ready_res;
    coord_t qx;
    coord_t qy;
    coord_t qz;
    logic   clipped;

    modport source (output valid, ready_res, qx, qy, qz, clipped, input ready);
    modport sink   (input valid, ready_res, qx, qy, qz, clipped, output ready);
endinterface

// ===== hdl/catmull_rom_spline_eval.sv =====
// Uniform Catmull-Rom evaluator over a window of the last four control points, with
// signed Q15.8 coordinates and an unsigned Q0.16 parameter t. A push beat shifts a point
// into the window and returns nothing, occupying the block while it does so. An evaluate
// beat returns one result: with fewer than four points held it gives ready_res low and
// zero coordinates; otherwise the single shared multiplier forms t^2, t^3 and the
// twelve point-weight products in turn under control of the microcode sequencer.
// Results are rounded to nearest (ties up) and clamped, with clipped set when any axis
// hit the range limit. A result waiting in the output register holds the sequencer at
// its final step until it is taken.
module catmull_rom_spline_eval
    import crs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    crs_in_if.sink    cmd,
    crs_out_if.source result
);

    ctl_t ctl;
    sts_t sts;

    crs_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    crs_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .sts    (sts),
        .cmd    (cmd),
        .result (result)
    );

endmodule

// ===== hdl/crs_seq.sv =====
module crs_seq
    import crs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output ctl_t ctl
);

    localparam logic [PC_W-1:0] PC_WAIT     = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DISPATCH = PC_W'(1);
    localparam logic [PC_W-1:0] PC_TSQ      = PC_W'(2);
    localparam logic [PC_W-1:0] PC_TCUBE    = PC_W'(3);
    localparam logic [PC_W-1:0] PC_T3       = PC_W'(4);
    localparam logic [PC_W-1:0] PC_WEIGHTS  = PC_W'(5);
    localparam logic [PC_W-1:0] PC_PROD0    = PC_W'(6);
    localparam logic [PC_W-1:0] PC_ACC_LAST = PC_W'(6 + NUM_PROD);
    localparam logic [PC_W-1:0] PC_FIN      = PC_W'(7 + NUM_PROD);
    localparam logic [PC_W-1:0] PC_PUSH     = PC_W'(8 + NUM_PROD);
    localparam logic [PC_W-1:0] PC_SHORT    = PC_W'(9 + NUM_PROD);
    localparam logic [PC_W-1:0] PC_LAST     = PC_SHORT;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    // Control store. The product steps issue one multiply per step and the
    // accumulate of each product follows in the next step.
    function automatic ctl_t rom(input logic [PC_W-1:0] pc);
        ctl_t       w;
        logic [3:0] k;
        w        = '0;
        w.mul_op = MUL_NONE;
        w.jc     = JC_NEXT;
        w.target = PC_WAIT;
        k        = '0;
        if ((pc >= PC_PROD0) && (pc < PC_ACC_LAST))
        begin
            k          = 4'(pc - PC_PROD0);
            w.mul_op   = MUL_PH;
            w.mul_axis = k[3:2];
            w.mul_pt   = k[1:0];
        end
        if ((pc > PC_PROD0) && (pc <= PC_ACC_LAST))
        begin
            k          = 4'(pc - PC_PROD0 - PC_W'(1));
            w.acc_en   = 1'b1;
            w.acc_axis = k[3:2];
            w.acc_load = (k[1:0] == 2'd0);
        end
        unique case (pc)
            PC_WAIT:
            begin
                w.in_take = 1'b1;
                w.jc      = JC_WAIT_IN;
            end
            PC_DISPATCH:
            begin
                w.jc     = JC_IF_PUSH;
                w.target = PC_PUSH;
            end
            PC_TSQ:
            begin
                w.mul_op = MUL_TT;
                w.jc     = JC_IF_SHORT;
                w.target = PC_SHORT;
            end
            PC_TCUBE:
            begin
                w.mul_op = MUL_T2T;
                w.ld_t2  = 1'b1;
            end
            PC_T3:      w.ld_t3 = 1'b1;
            PC_WEIGHTS: w.ld_h  = 1'b1;
            PC_FIN:
            begin
                w.out_wr = 1'b1;
                w.jc     = JC_WAIT_OUT;
            end
            PC_PUSH:
            begin
                w.push_en = 1'b1;
                w.jc      = JC_GOTO;
            end
            PC_SHORT:
            begin
                w.out_wr   = 1'b1;
                w.out_zero = 1'b1;
                w.jc       = JC_WAIT_OUT;
            end
            default:
            begin
                if (pc > PC_LAST)
                begin
                    w.jc = JC_GOTO;
                end
            end
        endcase
        return w;
    endfunction

    assign ctl = rom(pc_reg);

    always_comb
    begin
        unique case (ctl.jc)
            JC_NEXT:     pc_next = pc_reg + PC_W'(1);
            JC_GOTO:     pc_next = ctl.target;
            JC_WAIT_IN:  pc_next = sts.in_valid ? pc_reg + PC_W'(1) : pc_reg;
            JC_IF_PUSH:  pc_next = sts.is_push ? ctl.target : pc_reg + PC_W'(1);
            JC_IF_SHORT: pc_next = !sts.full ? ctl.target : pc_reg + PC_W'(1);
            JC_WAIT_OUT: pc_next = sts.out_free ? ctl.target : pc_reg;
            default:     pc_next = PC_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= PC_LAST)
        else $error("step counter left the program");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_FIN) && !sts.out_free |=> pc_reg == PC_FIN)
        else $error("final step abandoned while the output register was busy");

    a_short_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_SHORT) |-> !sts.full)
        else $error("not-ready result issued with a full window");

endmodule

// ===== hdl/crs_dp.sv =====
module crs_dp
    import crs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctl_t       ctl,
    output sts_t       sts,
    crs_in_if.sink     cmd,
    crs_out_if.source  result
);

    logic                  cmd_reg;
    coord_t                p_reg [AXES];
    frac_t                 t_reg;
    frac_t                 t2_reg;
    frac_t                 t3_reg;
    coord_t                win_reg [AXES][POINTS];
    logic [2:0]            points_reg;
    wgt_t                  h_reg [POINTS];
    logic signed [PW-1:0]  prod_reg;
    acc_t                  acc_reg [AXES];
    res_t                  res_reg;
    logic                  out_valid_reg;

    logic signed [MA_W-1:0] a_op;
    wgt_t                   b_op;
    wgt_t                   wt;
    wgt_t                   w2;
    wgt_t                   w3;
    wgt_t                   h_next [POINTS];
    frac_t                  t2_prod;
    acc_t                   addend;
    acc_t                   rnd [AXES];
    quot_t                  q [AXES];
    coord_t                 q_sat [AXES];
    logic [AXES-1:0]        sat;
    logic                   out_free;
    logic                   out_write;
    logic                   take;

    assign take      = cmd.valid && ctl.in_take;
    assign out_free  = !out_valid_reg || result.ready;
    assign out_write = ctl.out_wr && out_free;

    assign cmd.ready = ctl.in_take;

    assign sts.in_valid = cmd.valid;
    assign sts.is_push  = (cmd_reg == COMMAND_PUSH);
    assign sts.full     = points_reg[2];
    assign sts.out_free = out_free;

    assign t2_prod = prod_reg[2*T_BITS-1:T_BITS];

    always_comb
    begin
        unique case (ctl.mul_op)
            MUL_TT:
            begin
                a_op = MA_W'(t_reg);
                b_op = WGT_W'(t_reg);
            end
            MUL_T2T:
            begin
                a_op = MA_W'(t2_prod);
                b_op = WGT_W'(t_reg);
            end
            MUL_PH:
            begin
                a_op = MA_W'(win_reg[ctl.mul_axis][ctl.mul_pt]);
                b_op = h_reg[ctl.mul_pt];
            end
            default:
            begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    // Doubled Catmull-Rom basis from t, t^2 and t^3.
    always_comb
    begin
        wt = WGT_W'(t_reg);
        w2 = WGT_W'(t2_reg);
        w3 = WGT_W'(t3_reg);
        h_next[0] = -w3 + (w2 <<< 1) - wt;
        h_next[1] = (w3 <<< 1) + w3 - ((w2 <<< 2) + w2) + TWO_S;
        h_next[2] = -((w3 <<< 1) + w3) + (w2 <<< 2) + wt;
        h_next[3] = w3 - w2;
    end

    assign addend = ACC_W'(prod_reg);

    // Round half up, then clamp each axis to the coordinate range.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            rnd[a] = acc_reg[a] + ACC_HALF;
            q[a]   = QW'(rnd[a] >>> (T_BITS + 1));
            if (q[a] > Q_MAX)
            begin
                q_sat[a] = COORD_BITS'(Q_MAX);
                sat[a]   = 1'b1;
            end
            else if (q[a] < Q_MIN)
            begin
                q_sat[a] = COORD_BITS'(Q_MIN);
                sat[a]   = 1'b1;
            end
            else
            begin
                q_sat[a] = COORD_BITS'(q[a]);
                sat[a]   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg  <= cmd.command;
            p_reg[0] <= cmd.px;
            p_reg[1] <= cmd.py;
            p_reg[2] <= cmd.pz;
            t_reg    <= cmd.param_t;
        end
        if (ctl.push_en)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                for (int i = 0; i < POINTS - 1; i++)
                begin
                    win_reg[a][i] <= win_reg[a][i+1];
                end
                win_reg[a][POINTS-1] <= p_reg[a];
            end
        end
        if (ctl.mul_op != MUL_NONE)
        begin
            prod_reg <= a_op * b_op;
        end
        if (ctl.ld_t2)
        begin
            t2_reg <= t2_prod;
        end
        if (ctl.ld_t3)
        begin
            t3_reg <= t2_prod;
        end
        if (ctl.ld_h)
        begin
            h_reg <= h_next;
        end
        if (ctl.acc_en)
        begin
            acc_reg[ctl.acc_axis] <= ctl.acc_load ? addend
                                                  : acc_reg[ctl.acc_axis] + addend;
        end
        if (out_write)
        begin
            if (ctl.out_zero)
            begin
                res_reg <= '0;
            end
            else
            begin
                res_reg.ready_res <= 1'b1;
                res_reg.qx        <= q_sat[0];
                res_reg.qy        <= q_sat[1];
                res_reg.qz        <= q_sat[2];
                res_reg.clipped   <= |sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            points_reg    <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.push_en && !points_reg[2])
            begin
                points_reg <= points_reg + 3'd1;
            end
            if (out_write)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.ready_res = res_reg.ready_res;
    assign result.qx        = res_reg.qx;
    assign result.qy        = res_reg.qy;
    assign result.qz        = res_reg.qz;
    assign result.clipped   = res_reg.clipped;

    a_points_bound: assert property (@(posedge clk) disable iff (!rst_n)
        points_reg <= 3'd4)
        else $error("point count above four");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push_en && (points_reg != 3'd4) |=> points_reg == $past(points_reg) + 3'd1)
        else $error("push did not advance the point count");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.ready_res |->
            (res_reg.qx == '0) && (res_reg.qy == '0) && (res_reg.qz == '0)
            && !res_reg.clipped)
        else $error("not-ready result carries nonzero fields");

endmodule

// ===== verif/tb.sv =====
module tb;
    import crs_pkg::*;

    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 1250;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int DRAIN_CYCLES  = 50;

    localparam int MODE_FREE       = 0;
    localparam int MODE_SEND_GAPS  = 1;
    localparam int MODE_RECV_STALL = 2;
    localparam int MODE_BOTH       = 3;

    localparam coord_t C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam longint Q_HI  = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint Q_LO  = -Q_HI - 1;

    typedef struct packed {
        logic   command;
        coord_t px;
        coord_t py;
        coord_t pz;
        frac_t  param_t;
    } spline_beat_t;

    typedef struct {
        spline_beat_t beat;
        int           mode;
    } queued_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    crs_in_if  in_bus ();
    crs_out_if out_bus ();

    catmull_rom_spline_eval dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (in_bus),
        .result (out_bus)
    );

    always #4 clk = ~clk;

    logic         drv_valid = 1'b0;
    spline_beat_t drv_beat  = '0;
    logic         rx_ready  = 1'b0;
    logic         hold_off  = 1'b0;
    int           cur_mode  = MODE_FREE;
    int           beats_in  = 0;
    int           idle_cycles = 0;
    int           mismatches  = 0;

    assign in_bus.valid   = drv_valid;
    assign in_bus.command = drv_beat.command;
    assign in_bus.px      = drv_beat.px;
    assign in_bus.py      = drv_beat.py;
    assign in_bus.pz      = drv_beat.pz;
    assign in_bus.param_t = drv_beat.param_t;
    assign out_bus.ready  = rx_ready;

    queued_beat_t pending_beats[$];
    res_t         expected_points[$];

    // Shadow of the block's control-point window, indexed [axis][point], point 0 oldest.
    coord_t win [3][4];
    int     pts_held = 0;
    longint wgt [4];

    function automatic int unsigned send_gap_pct(int m);
        case (m)
            MODE_SEND_GAPS: return 67;
            MODE_BOTH:      return 10;
            default:        return 0;
        endcase
    endfunction

    function automatic int unsigned recv_stall_pct(int m);
        case (m)
            MODE_RECV_STALL: return 67;
            MODE_BOTH:       return 10;
            default:         return 0;
        endcase
    endfunction

    function automatic coord_t blend_axis(int ax, output bit sat);
        longint acc = 0;
        longint q;
        for (int i = 0; i < 4; i++)
            acc += longint'(win[ax][i]) * wgt[i];
        // The weights are doubled, so one extra bit of shift halves them while rounding.
        q = (acc + (longint'(1) <<< T_BITS)) >>> (T_BITS + 1);
        sat = 1'b0;
        if (q > Q_HI) begin
            q = Q_HI;
            sat = 1'b1;
        end else if (q < Q_LO) begin
            q = Q_LO;
            sat = 1'b1;
        end
        return coord_t'(q);
    endfunction

    function automatic void predict_beat(spline_beat_t b);
        longint tv;
        longint t2;
        longint t3;
        longint s;
        res_t   r;
        bit     cx;
        bit     cy;
        bit     cz;
        if (b.command == COMMAND_PUSH) begin
            for (int ax = 0; ax < 3; ax++)
                for (int i = 0; i < 3; i++)
                    win[ax][i] = win[ax][i+1];
            win[0][3] = b.px;
            win[1][3] = b.py;
            win[2][3] = b.pz;
            if (pts_held < 4)
                pts_held++;
            return;
        end
        r = '0;
        if (pts_held < 4) begin
            expected_points = {expected_points, r};
            return;
        end
        tv = longint'(b.param_t);
        s  = longint'(1) <<< T_BITS;
        t2 = (tv * tv) >>> T_BITS;
        t3 = (t2 * tv) >>> T_BITS;
        wgt[0] = -t3 + 2 * t2 - tv;
        wgt[1] = 3 * t3 - 5 * t2 + 2 * s;
        wgt[2] = -3 * t3 + 4 * t2 + tv;
        wgt[3] = t3 - t2;
        r.ready_res = 1'b1;
        r.qx = blend_axis(0, cx);
        r.qy = blend_axis(1, cy);
        r.qz = blend_axis(2, cz);
        r.clipped = cx | cy | cz;
        expected_points = {expected_points, r};
    endfunction

    function automatic coord_t pick_coord();
        int unsigned sel = $urandom_range(99);
        if (sel < 50)
            return coord_t'($urandom);
        if (sel < 75)
            return coord_t'(int'($urandom_range(4095)) - 2048);
        if (sel < 90) begin
            case ($urandom_range(3))
                0:       return C_MAX;
                1:       return C_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return coord_t'($urandom_range(1 << (COORD_BITS - 1), (1 << COORD_BITS) - 1)) ^
               ($urandom_range(1) ? coord_t'(0) : C_MAX);
    endfunction

    function automatic frac_t pick_t();
        if ($urandom_range(99) < 70)
            return frac_t'($urandom);
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return frac_t'(1);
            default: return frac_t'(1 << (T_BITS - 1));
        endcase
    endfunction

    function automatic spline_beat_t mk_push(coord_t x, coord_t y, coord_t z);
        spline_beat_t b;
        b.command = COMMAND_PUSH;
        b.px = x;
        b.py = y;
        b.pz = z;
        b.param_t = frac_t'($urandom);
        return b;
    endfunction

    function automatic spline_beat_t mk_eval(frac_t t);
        spline_beat_t b;
        b.command = COMMAND_EVAL;
        b.px = coord_t'($urandom);
        b.py = coord_t'($urandom);
        b.pz = coord_t'($urandom);
        b.param_t = t;
        return b;
    endfunction

    task automatic queue_beat(spline_beat_t b, int m);
        queued_beat_t e;
        e.beat = b;
        e.mode = m;
        pending_beats = {pending_beats, e};
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Input driver: presents queued beats, inserting gaps only between beats.
    always @(posedge clk or negedge rst_n) begin
        queued_beat_t nxt;
        if (!rst_n) begin
            drv_valid <= 1'b0;
            drv_beat  <= '0;
        end else begin
            if (drv_valid && in_bus.ready) begin
                predict_beat(drv_beat);
                beats_in <= beats_in + 1;
            end
            if (!drv_valid || in_bus.ready) begin
                if (pending_beats.size() != 0 &&
                    $urandom_range(99) >= send_gap_pct(pending_beats[0].mode)) begin
                    nxt = pending_beats[0];
                    pending_beats.delete(0);
                    drv_valid <= 1'b1;
                    drv_beat  <= nxt.beat;
                    cur_mode  <= nxt.mode;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted beat against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin
        res_t want;
        if (!rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            if (out_bus.valid && rx_ready) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got qx=%0d qy=%0d qz=%0d",
                             $time, out_bus.qx, out_bus.qy, out_bus.qz);
                    mismatches++;
                end else begin
                    want = expected_points[0];
                    expected_points.delete(0);
                    check_field("ready_res", want.ready_res, out_bus.ready_res);
                    check_field("qx", want.qx, out_bus.qx);
                    check_field("qy", want.qy, out_bus.qy);
                    check_field("qz", want.qz, out_bus.qz);
                    check_field("clipped", want.clipped, out_bus.clipped);
                end
            end
            rx_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct(cur_mode));
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((drv_valid && in_bus.ready) || (out_bus.valid && rx_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX) begin
                $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
                $display("catmull_rom_spline_eval verification failed");
                $finish;
            end
        end
    end

    // Hold the result side off long enough that the block backs up into its input.
    initial begin
        while (beats_in < HOLD_AT)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial begin
        int m;
        for (int ax = 0; ax < 3; ax++)
            for (int i = 0; i < 4; i++)
                win[ax][i] = '0;

        // Evaluates before the window is full must come back not ready.
        queue_beat(mk_eval(frac_t'(1 << (T_BITS - 1))), MODE_FREE);
        queue_beat(mk_push(C_MAX, C_MIN, '0), MODE_FREE);
        queue_beat(mk_eval('1), MODE_FREE);
        queue_beat(mk_push(C_MIN, C_MAX, '1), MODE_FREE);
        queue_beat(mk_push(coord_t'(256), coord_t'(-256), coord_t'(1)), MODE_FREE);
        queue_beat(mk_eval('0), MODE_FREE);
        queue_beat(mk_push(coord_t'(-5), coord_t'(12345), coord_t'(-77777)), MODE_FREE);
        queue_beat(mk_eval('0), MODE_FREE);
        queue_beat(mk_eval('1), MODE_FREE);
        queue_beat(mk_eval(frac_t'(1 << (T_BITS - 1))), MODE_FREE);
        queue_beat(mk_eval(frac_t'(1)), MODE_FREE);
        // Alternating extremes overshoot at mid-span and clip both ways.
        queue_beat(mk_push(C_MIN, C_MAX, '0), MODE_FREE);
        queue_beat(mk_push(C_MAX, C_MIN, '1), MODE_FREE);
        queue_beat(mk_push(C_MAX, C_MIN, coord_t'(1)), MODE_FREE);
        queue_beat(mk_push(C_MIN, C_MAX, '0), MODE_FREE);
        queue_beat(mk_eval(frac_t'(1 << (T_BITS - 1))), MODE_FREE);
        queue_beat(mk_eval('0), MODE_FREE);
        queue_beat(mk_eval('1), MODE_FREE);
        for (int i = 0; i < 4; i++)
            queue_beat(mk_push(C_MAX, C_MIN, C_MAX), MODE_FREE);
        queue_beat(mk_eval(frac_t'(1 << (T_BITS - 1))), MODE_FREE);

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            m = (i * 4) / RANDOM_BEATS;
            if ($urandom_range(99) < 55)
                queue_beat(mk_push(pick_coord(), pick_coord(), pick_coord()), m);
            else
                queue_beat(mk_eval(pick_t()), m);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || drv_valid)
            @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_points.size() == 0)
            $display("catmull_rom_spline_eval verification clean");
        else
            $display("catmull_rom_spline_eval verification failed");
        $finish;
    end

endmodule

// ===== catmull_rom_spline_eval.f =====
hdl/crs_pkg.sv
hdl/crs_in_if.sv
hdl/crs_out_if.sv
hdl/crs_seq.sv
hdl/crs_dp.sv
hdl/catmull_rom_spline_eval.sv
verif/tb.sv
